@@ hw/rtl/rmio_pkg.sv @@
// shared types and constants for the real-mode i/o trap emulator
`timescale 1ns / 1ps
package rmio_pkg;

    localparam int MaxPrefixes = 14;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_BYTE  = 2'd2,
        CMD_PORT  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_DONE     = 3'd0,
        KIND_REG      = 3'd1,
        KIND_PORT_RD  = 3'd2,
        KIND_PORT_WR  = 3'd3,
        KIND_STR_IN   = 3'd4,
        KIND_STR_OUT  = 3'd5,
        KIND_HALT     = 3'd6,
        KIND_FAULT    = 3'd7
    } kind_t;

    localparam logic [3:0] R_EAX    = 4'd0;
    localparam logic [3:0] R_ECX    = 4'd1;
    localparam logic [3:0] R_EDX    = 4'd2;
    localparam logic [3:0] R_ESI    = 4'd6;
    localparam logic [3:0] R_EDI    = 4'd7;
    localparam logic [3:0] R_EIP    = 4'd8;
    localparam logic [3:0] R_EFLAGS = 4'd9;
    localparam logic [3:0] R_DS     = 4'd11;
    localparam logic [3:0] R_ES     = 4'd12;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  reg_sel;
        logic [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] port;
        logic [1:0]  width_code;
        logic [31:0] data;
        logic [20:0] linear_address;
        logic [31:0] count;
        logic        backward;
    } out_item_t;

    // decoded operation handed from front to back
    typedef enum logic [2:0] {
        OP_WRITE,
        OP_READ,
        OP_STRING,
        OP_PORT,
        OP_STOP,
        OP_MERGE
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [3:0]  reg_sel;
        logic [31:0] value;
        logic [2:0]  kind;
        logic [1:0]  wc;
        logic        from_dx;
        logic [15:0] imm_port;
        logic [4:0]  ip_inc;
        logic        rep;
        logic        wide;
        logic [2:0]  seg;
    } task_t;

endpackage

@@ hw/rtl/rmio_front.sv @@
// front end: prefix collection and opcode classification
`timescale 1ns / 1ps
module rmio_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid,
    output logic              stall,
    input  rmio_pkg::in_item_t item,
    output logic              task_valid,
    output rmio_pkg::task_t   task_item,
    input  logic              task_stall
);
    import rmio_pkg::*;

    logic       osz_reg, osz_next, asz_reg, asz_next, rep_reg, rep_next;
    logic [2:0] seg_reg, seg_next;
    logic [1:0] phase_reg, phase_next;
    logic [7:0] op_reg, op_next;
    logic [3:0] pc_reg, pc_next;
    logic       emit;
    task_t      t;
    logic [7:0] b;
    logic       is_pfx;
    logic [2:0] s;
    logic [1:0] wcw;

    assign stall = task_stall;
    assign task_valid = valid && emit;
    assign task_item = t;
    assign b = item.value[7:0];

    always_comb
    begin
        osz_next = osz_reg; asz_next = asz_reg; rep_next = rep_reg;
        seg_next = seg_reg; phase_next = phase_reg; op_next = op_reg; pc_next = pc_reg;
        emit = 1'b0;
        t = '0;
        t.op = OP_WRITE;
        t.reg_sel = item.reg_sel;
        t.value = item.value;
        t.rep = rep_reg;
        t.wide = osz_reg ^ asz_reg;
        t.seg = seg_reg;
        is_pfx = 1'b1;
        s = 3'd0;
        wcw = osz_reg ? 2'd2 : 2'd1;
        case (b)
            8'h66, 8'h67, 8'hF2, 8'hF3: s = 3'd0;
            8'h2E: s = 3'd1;
            8'h3E: s = 3'd2;
            8'h26: s = 3'd3;
            8'h36: s = 3'd4;
            8'h64: s = 3'd5;
            8'h65: s = 3'd6;
            default: is_pfx = 1'b0;
        endcase
        case (item.cmd)
            CMD_WRITE: emit = 1'b1;
            CMD_READ:
            begin
                emit = 1'b1;
                t.op = OP_READ;
            end
            CMD_BYTE:
            begin
                if (phase_reg == 2'd1) begin
                    emit = 1'b1;
                    t.op = OP_PORT;
                    t.imm_port = {8'h00, b};
                    t.wc = op_reg[0] ? wcw : 2'd0;
                    t.kind = op_reg[1] ? KIND_PORT_WR : KIND_PORT_RD;
                    t.ip_inc = {1'b0, pc_reg} + 5'd2;
                    if (op_reg[1]) begin
                        {osz_next, asz_next, rep_next} = 3'b000;
                        seg_next = '0; pc_next = '0; op_next = '0; phase_next = 2'd0;
                    end else begin
                        phase_next = 2'd2;
                    end
                end else if (phase_reg == 2'd0) begin
                    if (is_pfx) begin
                        if (pc_reg >= 4'(MaxPrefixes)) begin
                            emit = 1'b1;
                            t.op = OP_STOP;
                            t.kind = KIND_FAULT;
                            t.ip_inc = {1'b0, pc_reg};
                            {osz_next, asz_next, rep_next} = 3'b000;
                            seg_next = '0; pc_next = '0; op_next = '0;
                        end else begin
                            if (b == 8'h66) osz_next = 1'b1;
                            if (b == 8'h67) asz_next = 1'b1;
                            if (b == 8'hF2 || b == 8'hF3) rep_next = 1'b1;
                            if (s != 3'd0) seg_next = s;
                            pc_next = pc_reg + 4'd1;
                        end
                    end else begin
                        emit = 1'b1;
                        t.ip_inc = {1'b0, pc_reg} + 5'd1;
                        t.wc = b[0] ? wcw : 2'd0;
                        t.kind = b[1] ? KIND_PORT_WR : KIND_PORT_RD;
                        {osz_next, asz_next, rep_next} = 3'b000;
                        seg_next = '0; pc_next = '0; op_next = '0;
                        if (b inside {[8'h6C:8'h6F]}) begin
                            t.op = OP_STRING;
                            t.kind = b[1] ? KIND_STR_OUT : KIND_STR_IN;
                        end else if (b inside {[8'hE4:8'hE7]}) begin
                            emit = 1'b0;
                            osz_next = osz_reg; asz_next = asz_reg; rep_next = rep_reg;
                            seg_next = seg_reg; pc_next = pc_reg;
                            op_next = b; phase_next = 2'd1;
                        end else if (b inside {[8'hEC:8'hEF]}) begin
                            t.op = OP_PORT;
                            t.from_dx = 1'b1;
                            if (!b[1]) begin
                                osz_next = osz_reg; pc_next = pc_reg;
                                asz_next = asz_reg; rep_next = rep_reg; seg_next = seg_reg;
                                op_next = b; phase_next = 2'd2;
                            end
                        end else begin
                            t.op = OP_STOP;
                            t.kind = (b == 8'hF4) ? KIND_HALT : KIND_FAULT;
                            t.wc = 2'd0;
                            t.ip_inc = {1'b0, pc_reg};
                        end
                    end
                end
            end
            default:
            begin
                if (phase_reg == 2'd2) begin
                    emit = 1'b1;
                    t.op = OP_MERGE;
                    t.wc = op_reg[0] ? wcw : 2'd0;
                    {osz_next, asz_next, rep_next} = 3'b000;
                    seg_next = '0; pc_next = '0; op_next = '0; phase_next = 2'd0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            osz_reg <= 1'b0; asz_reg <= 1'b0; rep_reg <= 1'b0;
            seg_reg <= '0; phase_reg <= '0; op_reg <= '0; pc_reg <= '0;
        end else if (valid && !stall) begin
            osz_reg <= osz_next; asz_reg <= asz_next; rep_reg <= rep_next;
            seg_reg <= seg_next; phase_reg <= phase_next; op_reg <= op_next;
            pc_reg <= pc_next;
        end
    end
endmodule

@@ hw/rtl/rmio_queue.sv @@
// two-entry queue between front and back
`timescale 1ns / 1ps
module rmio_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  rmio_pkg::task_t in_item,
    output logic            out_valid,
    input  logic            out_stall,
    output rmio_pkg::task_t out_item
);
    import rmio_pkg::*;

    task_t      mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_stall = (cnt_reg == 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item = mem_reg[rp_reg];
    assign push = in_valid && !in_stall;
    assign pop = out_valid && !out_stall;

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= in_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

@@ hw/rtl/rmio_back.sv @@
// back end: register file, execution and result register
`timescale 1ns / 1ps
module rmio_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               task_valid,
    output logic               task_stall,
    input  rmio_pkg::task_t    task_item,
    output logic               valid,
    input  logic               stall,
    output rmio_pkg::out_item_t item
);
    import rmio_pkg::*;

    logic [31:0] rf_reg [16];
    logic [31:0] rf_next [16];
    out_item_t   item_reg, res;
    logic        valid_reg, emit, fire;
    logic [3:0]  idx, segi;
    logic [31:0] cnt, delta, a;
    logic [15:0] off;
    logic [31:0] ip;
    logic [15:0] ipl;

    assign task_stall = valid_reg && stall;
    assign fire = task_valid && !task_stall;
    assign valid = valid_reg;
    assign item = item_reg;

    always_comb
    begin
        rf_next = rf_reg;
        res = '0;
        emit = 1'b1;
        idx = task_item.kind[0] ? R_ESI : R_EDI;
        segi = R_ES;
        if (task_item.kind[0]) segi = (task_item.seg == 3'd0) ? R_DS : 4'(4'd9 + task_item.seg);
        cnt = 32'd1;
        if (task_item.rep) cnt = task_item.wide ? rf_reg[R_ECX] : {16'h0, rf_reg[R_ECX][15:0]};
        delta = cnt << task_item.wc;
        off = rf_reg[idx][15:0];
        ip = rf_reg[R_EIP];
        ipl = ip[15:0] + {11'h0, task_item.ip_inc};
        a = rf_reg[R_EAX];
        res.kind = task_item.kind;
        res.width_code = task_item.wc;
        case (task_item.op)
            OP_WRITE:
            begin
                emit = 1'b0;
                rf_next[task_item.reg_sel] = task_item.value;
            end
            OP_READ:
            begin
                res.kind = KIND_REG;
                res.width_code = '0;
                res.data = rf_reg[task_item.reg_sel];
            end
            OP_STRING:
            begin
                res.port = rf_reg[R_EDX][15:0];
                res.linear_address = {1'b0, rf_reg[segi][15:0], 4'h0} + {5'h0, off};
                res.count = cnt;
                res.backward = rf_reg[R_EFLAGS][10];
                if (task_item.rep) begin
                    if (task_item.wide) rf_next[R_ECX] = '0;
                    else rf_next[R_ECX] = {rf_reg[R_ECX][31:16], 16'h0};
                end
                rf_next[idx] = {rf_reg[idx][31:16],
                    rf_reg[R_EFLAGS][10] ? off - delta[15:0] : off + delta[15:0]};
                rf_next[R_EIP] = {ip[31:16], ipl};
            end
            OP_PORT:
            begin
                res.port = task_item.from_dx ? rf_reg[R_EDX][15:0] : task_item.imm_port;
                if (task_item.kind == KIND_PORT_WR) begin
                    case (task_item.wc)
                        2'd0: res.data = {24'h0, a[7:0]};
                        2'd1: res.data = {16'h0, a[15:0]};
                        default: res.data = a;
                    endcase
                end
                rf_next[R_EIP] = {ip[31:16], ipl};
            end
            OP_STOP:
            begin
                rf_next[R_EIP] = {ip[31:16], ipl};
            end
            OP_MERGE:
            begin
                res.kind = KIND_DONE;
                case (task_item.wc)
                    2'd0: rf_next[R_EAX] = {a[31:8], task_item.value[7:0]};
                    2'd1: rf_next[R_EAX] = {a[31:16], task_item.value[15:0]};
                    default: rf_next[R_EAX] = task_item.value;
                endcase
            end
            default: emit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            for (int i = 0; i < 16; i++) rf_reg[i] <= '0;
        end else begin
            if (fire) rf_reg <= rf_next;
            if (fire && emit) valid_reg <= 1'b1;
            else if (!stall) valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit) item_reg <= res;
    end
endmodule

@@ hw/rtl/real_mode_io_trap_emulator_unit.sv @@
// top level of the real-mode i/o trap emulator
// the path from input transfer to result runs through the queue and the result register
// throughput: one item per cycle when neither side stalls
// the two-entry queue lets the decoder run while the executor waits on the output
// reset clears the register file, prefix state and all valid flags at once
`timescale 1ns / 1ps
module real_mode_io_trap_emulator_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  rmio_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output rmio_pkg::out_item_t out_item
);
    import rmio_pkg::*;

    logic  f_valid, f_stall, b_valid, b_stall;
    task_t f_task, b_task;

    rmio_front u_front (
        .clk, .rst_n, .valid(in_valid), .stall(in_stall), .item(in_item),
        .task_valid(f_valid), .task_item(f_task), .task_stall(f_stall)
    );

    rmio_queue u_queue (
        .clk, .rst_n, .in_valid(f_valid), .in_stall(f_stall), .in_item(f_task),
        .out_valid(b_valid), .out_stall(b_stall), .out_item(b_task)
    );

    rmio_back u_back (
        .clk, .rst_n, .task_valid(b_valid), .task_stall(b_stall), .task_item(b_task),
        .valid(out_valid), .stall(out_stall), .item(out_item)
    );
endmodule

@@ sim/tb_real_mode_io_trap_emulator_unit.sv @@
// testbench for the real-mode i/o trap emulator: predicts each result and checks it
`timescale 1ns / 1ps
module tb_real_mode_io_trap_emulator_unit;
    import rmio_pkg::*;

    localparam logic [3:0] R_SEG_BASE = 4'd9;
    localparam logic [7:0] B_OPSIZE = 8'h66;
    localparam logic [7:0] B_ADSIZE = 8'h67;
    localparam logic [7:0] B_CS = 8'h2e;
    localparam logic [7:0] B_DS = 8'h3e;
    localparam logic [7:0] B_ES = 8'h26;
    localparam logic [7:0] B_SS = 8'h36;
    localparam logic [7:0] B_FS = 8'h64;
    localparam logic [7:0] B_GS = 8'h65;
    localparam logic [7:0] B_REPNE = 8'hf2;
    localparam logic [7:0] B_REP = 8'hf3;
    localparam logic [7:0] B_LOCK = 8'hf0;
    localparam logic [7:0] B_TWO_BYTE = 8'h0f;
    localparam logic [7:0] B_INSB = 8'h6c;
    localparam logic [7:0] B_INSW = 8'h6d;
    localparam logic [7:0] B_OUTSB = 8'h6e;
    localparam logic [7:0] B_OUTSW = 8'h6f;
    localparam logic [7:0] B_IN_IMM = 8'he4;
    localparam logic [7:0] B_OUT_IMM = 8'he6;
    localparam logic [7:0] B_IN_DX = 8'hec;
    localparam logic [7:0] B_OUT_DX = 8'hee;
    localparam logic [7:0] B_HLT = 8'hf4;
    localparam logic [31:0] DF_MASK = 32'h0000_0400;
    localparam logic [1:0] PH_OPCODE = 2'd0;
    localparam logic [1:0] PH_IMM = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_item_t in_item;
    logic out_valid;
    logic out_stall;
    out_item_t out_item;

    logic [31:0] regs [16];
    logic op16;
    logic ad16;
    logic rep;
    logic [2:0] seg_sel;
    logic [1:0] phase;
    logic [7:0] held_op;
    int unsigned npref;

    out_item_t pending_results[$];
    int errors;
    bit fail_flag;

    real_mode_io_trap_emulator_unit i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item(out_item)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic out_item_t mk(logic [2:0] k, logic [15:0] p, logic [1:0] w,
                                     logic [31:0] d, logic [20:0] la, logic [31:0] c,
                                     logic b);
        out_item_t r;
        r.kind = k;
        r.port = p;
        r.width_code = w;
        r.data = d;
        r.linear_address = la;
        r.count = c;
        r.backward = b;
        return r;
    endfunction

    function automatic void clear_state();
        op16 = 0;
        ad16 = 0;
        rep = 0;
        seg_sel = 0;
        npref = 0;
        held_op = 0;
        phase = PH_OPCODE;
    endfunction

    function automatic void bump_ip(int unsigned n);
        regs[R_EIP][15:0] = regs[R_EIP][15:0] + 16'(n);
    endfunction

    function automatic logic [1:0] size_of(logic [7:0] op);
        return op[0] ? (op16 ? 2'd2 : 2'd1) : 2'd0;
    endfunction

    function automatic void stop_insn(logic [2:0] k);
        bump_ip(npref);
        pending_results.push_back(mk(k, 0, 0, 0, 0, 0, 0));
        clear_state();
    endfunction

    function automatic void port_insn(logic [7:0] op, logic [15:0] p, int unsigned len);
        logic [1:0] w;
        logic [31:0] d;
        w = size_of(op);
        bump_ip(npref + len);
        if (op[1]) begin
            d = w == 2'd0 ? {24'd0, regs[R_EAX][7:0]} :
                w == 2'd1 ? {16'd0, regs[R_EAX][15:0]} : regs[R_EAX];
            pending_results.push_back(mk(KIND_PORT_WR, p, w, d, 0, 0, 0));
            clear_state();
        end
        else begin
            pending_results.push_back(mk(KIND_PORT_RD, p, w, 0, 0, 0, 0));
            held_op = op;
            phase = PH_DATA;
        end
    endfunction

    function automatic void string_insn(logic [7:0] op);
        logic [1:0] w;
        logic wide;
        logic [31:0] cnt;
        logic back;
        logic is_in;
        logic [3:0] idx;
        logic [3:0] sreg;
        logic [15:0] off;
        logic [20:0] lin;
        w = size_of(op);
        wide = op16 ^ ad16;
        cnt = 1;
        back = (regs[R_EFLAGS] & DF_MASK) != 0;
        is_in = op < 8'h6e;
        idx = is_in ? R_EDI : R_ESI;
        sreg = is_in ? R_ES : (seg_sel != 0 ? R_SEG_BASE + 4'(seg_sel) : R_DS);
        off = regs[idx][15:0];
        lin = {1'b0, regs[sreg][15:0], 4'd0} + 21'(off);
        if (rep) begin
            cnt = wide ? regs[R_ECX] : {16'd0, regs[R_ECX][15:0]};
            if (wide)
                regs[R_ECX] = 0;
            else
                regs[R_ECX][15:0] = 0;
        end
        if (back)
            off = off - 16'(cnt << w);
        else
            off = off + 16'(cnt << w);
        regs[idx][15:0] = off;
        bump_ip(npref + 1);
        pending_results.push_back(mk(is_in ? KIND_STR_IN : KIND_STR_OUT, regs[R_EDX][15:0],
                                     w, 0, lin, cnt, back));
        clear_state();
    endfunction

    function automatic void decode_byte(logic [7:0] b);
        logic [2:0] s;
        logic pre;
        s = 0;
        pre = 1;
        if (phase == PH_IMM) begin
            port_insn(held_op, {8'd0, b}, 2);
            return;
        end
        case (b)
            B_OPSIZE: op16 = 1;
            B_ADSIZE: ad16 = 1;
            B_CS: s = 1;
            B_DS: s = 2;
            B_ES: s = 3;
            B_SS: s = 4;
            B_FS: s = 5;
            B_GS: s = 6;
            B_REPNE, B_REP: rep = 1;
            default: pre = 0;
        endcase
        if (pre) begin
            if (npref >= MaxPrefixes) begin
                stop_insn(KIND_FAULT);
                return;
            end
            if (s != 0)
                seg_sel = s;
            npref++;
            return;
        end
        case (b)
            B_INSB, B_INSW, B_OUTSB, B_OUTSW: string_insn(b);
            B_IN_IMM, 8'he5, B_OUT_IMM, 8'he7:
            begin
                held_op = b;
                phase = PH_IMM;
            end
            B_IN_DX, 8'hed, B_OUT_DX, 8'hef: port_insn(b, regs[R_EDX][15:0], 1);
            B_HLT: stop_insn(KIND_HALT);
            default: stop_insn(KIND_FAULT);
        endcase
    endfunction

    function automatic void predict(in_item_t it);
        logic [1:0] w;
        case (cmd_t'(it.cmd))
            CMD_WRITE: regs[it.reg_sel] = it.value;
            CMD_READ: pending_results.push_back(mk(KIND_REG, 0, 0, regs[it.reg_sel], 0, 0, 0));
            CMD_BYTE:
            begin
                if (phase != PH_DATA)
                    decode_byte(it.value[7:0]);
            end
            default:
            begin
                if (phase == PH_DATA) begin
                    w = size_of(held_op);
                    if (w == 2'd0)
                        regs[R_EAX][7:0] = it.value[7:0];
                    else if (w == 2'd1)
                        regs[R_EAX][15:0] = it.value[15:0];
                    else
                        regs[R_EAX] = it.value;
                    pending_results.push_back(mk(KIND_DONE, 0, w, 0, 0, 0, 0));
                    clear_state();
                end
            end
        endcase
    endfunction

    int burst_left;

    task automatic send(cmd_t c, logic [3:0] sel, logic [31:0] v);
        in_item_t it;
        int gap;
        it.cmd = c;
        it.reg_sel = sel;
        it.value = v;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict(it);
    endtask

    task automatic idle_bus();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        idle_bus();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_byte(logic [7:0] b);
        send(CMD_BYTE, 4'($urandom), {$urandom_range(0, 1) ? 24'($urandom) : 24'd0, b});
    endtask

    task automatic test_registers();
        for (int i = 0; i < 16; i++)
            send(CMD_WRITE, 4'(i), i[0] ? 32'hffff_ffff : 32'h0000_0000);
        for (int i = 0; i < 16; i++)
            send(CMD_READ, 4'(i), $urandom);
        send(CMD_WRITE, R_EDX, 32'h0000_fffe);
    endtask

    task automatic test_directed_insns();
        send(CMD_WRITE, R_ECX, 32'h0001_0003);
        put_byte(B_REP);
        put_byte(B_INSW);
        send(CMD_WRITE, R_EFLAGS, DF_MASK);
        put_byte(B_OPSIZE);
        put_byte(B_REP);
        put_byte(B_FS);
        put_byte(B_OUTSW);
        put_byte(B_IN_IMM);
        put_byte(8'hff);
        put_byte(B_HLT);
        send(CMD_PORT, 0, 32'hdead_beef);
        put_byte(B_OUT_DX);
        put_byte(B_LOCK);
        put_byte(B_TWO_BYTE);
        for (int i = 0; i < 15; i++)
            put_byte(B_ES);
        send(CMD_READ, R_EIP, 0);
        send(CMD_READ, R_ESI, 0);
    endtask

    task automatic test_pause_until_empty();
        drain();
        put_byte(B_IN_DX);
        drain();
        send(CMD_PORT, 0, $urandom);
    endtask

    function automatic logic [7:0] pick_prefix();
        logic [7:0] p [10] = '{B_OPSIZE, B_ADSIZE, B_CS, B_DS, B_ES, B_SS, B_FS, B_GS,
                                B_REPNE, B_REP};
        return p[$urandom_range(0, 9)];
    endfunction

    function automatic logic [7:0] pick_opcode();
        case ($urandom_range(0, 9))
            0, 1, 2: return 8'h6c + 8'($urandom_range(0, 3));
            3, 4: return 8'he4 + 8'($urandom_range(0, 3));
            5, 6: return 8'hec + 8'($urandom_range(0, 3));
            7: return B_HLT;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic test_random();
        int items;
        logic [7:0] op;
        items = 0;
        while (items < 800) begin
            case ($urandom_range(0, 9))
                0, 1: send(CMD_WRITE, 4'($urandom), $urandom_range(0, 3) == 0 ? $urandom :
                           ($urandom & 32'h0000_0fff) | ($urandom_range(0, 1) ? DF_MASK : 0));
                2: send(CMD_READ, 4'($urandom), $urandom);
                3: send(CMD_PORT, 0, $urandom);
                default:
                begin
                    repeat ($urandom_range(0, 5) == 0 ? $urandom_range(0, 16)
                                                      : $urandom_range(0, 3))
                    begin
                        put_byte(pick_prefix());
                        items++;
                    end
                    op = pick_opcode();
                    put_byte(op);
                    if (op >= 8'he4 && op <= 8'he7)
                        put_byte(8'($urandom));
                    if ((op == 8'he4 || op == 8'he5 || op == 8'hec || op == 8'hed)
                        && $urandom_range(0, 7) != 0)
                        send(CMD_PORT, 0, $urandom);
                    items += 2;
                end
            endcase
            items++;
        end
    endtask

    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 3) == 0) && ($time % 4000 < 2800);
    end

    always @(posedge clk) begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with no expectation: kind %0d", out_item.kind);
                errors++;
            end
            else begin
                want = pending_results.pop_front();
                if (out_item.kind !== want.kind) begin
                    $error("kind: expected %0d actual %0d", want.kind, out_item.kind);
                    errors++;
                end
                if (out_item.port !== want.port) begin
                    $error("port: expected %h actual %h", want.port, out_item.port);
                    errors++;
                end
                if (out_item.width_code !== want.width_code) begin
                    $error("width_code: expected %0d actual %0d", want.width_code,
                           out_item.width_code);
                    errors++;
                end
                if (out_item.data !== want.data) begin
                    $error("data: expected %h actual %h", want.data, out_item.data);
                    errors++;
                end
                if (out_item.linear_address !== want.linear_address) begin
                    $error("linear_address: expected %h actual %h", want.linear_address,
                           out_item.linear_address);
                    errors++;
                end
                if (out_item.count !== want.count) begin
                    $error("count: expected %h actual %h", want.count, out_item.count);
                    errors++;
                end
                if (out_item.backward !== want.backward) begin
                    $error("backward: expected %0d actual %0d", want.backward,
                           out_item.backward);
                    errors++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("real_mode_io_trap_emulator_unit regression: fail");
        $finish;
    end

    initial begin
        errors = 0;
        burst_left = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        for (int i = 0; i < 16; i++)
            regs[i] = 0;
        clear_state();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_registers();
        test_directed_insns();
        test_pause_until_empty();
        test_random();
        drain();
        fail_flag = errors != 0 || pending_results.size() != 0;
        if (!fail_flag)
            $display("real_mode_io_trap_emulator_unit regression: pass");
        else
            $display("real_mode_io_trap_emulator_unit regression: fail");
        $finish;
    end
endmodule
